/* rtl/scpd_pkg.sv */
package scpd_pkg;

    localparam int MAX_ROWS  = 1024;
    localparam int ROWS_W    = 11;
    localparam int PL_W      = ROWS_W + 3;
    localparam int STORE_W   = 24;
    localparam int CNT_W     = 5;
    localparam int LEN_W     = 9;
    localparam int MAX_RES   = 10;
    localparam int RES_CNT_W = 4;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    // register indexes on the configuration port
    localparam logic [1:0] REG_COLOR_BITS   = 2'd0;
    localparam logic [1:0] REG_TRANSP_ON    = 2'd1;
    localparam logic [1:0] REG_TRANSP_COLOR = 2'd2;
    localparam logic [1:0] REG_STRIP_ROWS   = 2'd3;

    localparam logic [3:0]        COLOR_BITS_RESET = 4'd8;
    localparam logic [3:0]        COLOR_BITS_MAX   = 4'd8;
    localparam logic [ROWS_W-1:0] STRIP_ROWS_RESET = ROWS_W'(128);

    // code field values
    localparam logic [2:0] WRAP_RUN_CODE = 3'd4;
    localparam logic [7:0] WRAP_BIAS     = 8'd4;

    typedef struct packed {
        logic [3:0]        color_bits;
        logic              transparent_on;
        logic [7:0]        transparent_color;
        logic [ROWS_W-1:0] strip_rows;
    } scpd_cfg_t;

    typedef struct packed {
        logic accept;
        logic emit_start;
        logic emit_code;
    } scpd_cmd_t;

    typedef struct packed {
        logic             active;
        logic             code_ok;
        logic             emit_done;
        logic             slot_free;
        logic [CNT_W-1:0] bit_cnt;
    } scpd_sts_t;

endpackage

/* rtl/scpd_cfg.sv */
module scpd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scpd_pkg::ADDR_W-1:0]   paddr,
    input  logic [scpd_pkg::DATA_W-1:0]   pwdata,
    output logic [scpd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output scpd_pkg::scpd_cfg_t           cfg
);
    import scpd_pkg::*;

    scpd_cfg_t  cfg_reg;
    scpd_cfg_t  cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_COLOR_BITS:   cfg_next.color_bits        = pwdata[3:0];
                REG_TRANSP_ON:    cfg_next.transparent_on    = pwdata[0];
                REG_TRANSP_COLOR: cfg_next.transparent_color = pwdata[7:0];
                REG_STRIP_ROWS:   cfg_next.strip_rows        = pwdata[ROWS_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_COLOR_BITS:   prdata = DATA_W'(cfg_reg.color_bits);
            REG_TRANSP_ON:    prdata = DATA_W'(cfg_reg.transparent_on);
            REG_TRANSP_COLOR: prdata = DATA_W'(cfg_reg.transparent_color);
            REG_STRIP_ROWS:   prdata = DATA_W'(cfg_reg.strip_rows);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_bits        <= COLOR_BITS_RESET;
            cfg_reg.transparent_on    <= 1'b0;
            cfg_reg.transparent_color <= 8'd0;
            cfg_reg.strip_rows        <= STRIP_ROWS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/scpd_ctrl.sv */
module scpd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 strip_start,
    output logic                 in_stall,
    input  scpd_pkg::scpd_sts_t  sts,
    output scpd_pkg::scpd_cmd_t  cmd
);
    import scpd_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_DECODE = 2'd2;

    localparam logic [RES_CNT_W-1:0] RES_LIMIT = RES_CNT_W'(MAX_RES);

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [RES_CNT_W-1:0] res_cnt_reg;
    logic [RES_CNT_W-1:0] res_cnt_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        res_cnt_next = res_cnt_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept   = 1'b1;
                    res_cnt_next = '0;
                    if (strip_start)
                        state_next = ST_START;
                    else if (sts.active)
                        state_next = ST_DECODE;
                end
            end
            ST_START:
            begin
                // start pixel, no bits to decode afterwards
                if (sts.slot_free)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DECODE:
            begin
                if (!sts.code_ok || res_cnt_reg == RES_LIMIT)
                    state_next = ST_IDLE;
                else if (sts.slot_free)
                begin
                    cmd.emit_code = 1'b1;
                    res_cnt_next  = res_cnt_reg + 1'b1;
                    if (sts.emit_done)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            res_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            res_cnt_reg <= res_cnt_next;
        end
    end

endmodule

/* rtl/scpd_dp.sv */
module scpd_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scpd_pkg::scpd_cfg_t           cfg,
    input  scpd_pkg::scpd_cmd_t           cmd,
    output scpd_pkg::scpd_sts_t           sts,
    input  logic [7:0]                    data_byte,
    input  logic                          strip_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    color_index,
    output logic [scpd_pkg::LEN_W-1:0]    run_length,
    output logic                          is_transparent,
    output logic                          strip_done
);
    import scpd_pkg::*;

    logic [STORE_W-1:0] store_reg, store_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         color_reg, color_next;
    logic [PL_W-1:0]    pl_reg, pl_next;
    logic               active_reg, active_next;

    logic               ov_reg, ov_next;
    logic [7:0]         oc_reg, oc_next;
    logic [LEN_W-1:0]   ol_reg, ol_next;
    logic               ot_reg, ot_next;
    logic               od_reg, od_next;

    // decode of the code at the bottom of the bit store
    logic [3:0]         cb;
    logic [7:0]         mask8;
    logic [CNT_W-1:0]   color_need;
    logic [2:0]         wrap_v;
    logic [7:0]         run_n;
    logic               code_ok;
    logic [3:0]         consume;
    logic [LEN_W-1:0]   dec_len;
    logic [7:0]         dec_color;

    logic               emit;
    logic [LEN_W-1:0]   em_len;
    logic [7:0]         em_color;
    logic [LEN_W-1:0]   take;
    logic [PL_W-1:0]    pl_after;
    logic               em_done;
    logic [ROWS_W-1:0]  rows_c;

    assign cb         = (cfg.color_bits > COLOR_BITS_MAX) ? COLOR_BITS_MAX : cfg.color_bits;
    assign mask8      = 8'((9'd1 << cb) - 9'd1);
    assign color_need = CNT_W'(2) + CNT_W'(cb);
    assign wrap_v     = store_reg[4:2];
    assign run_n      = store_reg[12:5];

    always_comb
    begin
        code_ok   = 1'b0;
        consume   = 4'd0;
        dec_len   = LEN_W'(1);
        dec_color = color_reg;
        if (active_reg && cnt_reg >= CNT_W'(1))
        begin
            if (!store_reg[0])
            begin
                code_ok = 1'b1;
                consume = 4'd1;
            end
            else if (cnt_reg >= CNT_W'(2))
            begin
                if (!store_reg[1])
                begin
                    if (cnt_reg >= color_need)
                    begin
                        code_ok   = 1'b1;
                        consume   = color_need[3:0];
                        dec_color = store_reg[9:2] & mask8;
                    end
                end
                else if (cnt_reg >= CNT_W'(5))
                begin
                    if (wrap_v != WRAP_RUN_CODE)
                    begin
                        code_ok   = 1'b1;
                        consume   = 4'd5;
                        dec_color = color_reg + {5'd0, wrap_v} - WRAP_BIAS;
                    end
                    else if (cnt_reg >= CNT_W'(13))
                    begin
                        code_ok = 1'b1;
                        consume = 4'd13;
                        dec_len = (run_n == 8'd0) ? LEN_W'(256) : LEN_W'(run_n);
                    end
                end
            end
        end
    end

    // run is cut at the strip end
    assign emit     = cmd.emit_start || cmd.emit_code;
    assign em_len   = cmd.emit_start ? LEN_W'(1) : dec_len;
    assign em_color = cmd.emit_start ? color_reg : dec_color;
    assign take     = (PL_W'(em_len) > pl_reg) ? pl_reg[LEN_W-1:0] : em_len;
    assign pl_after = pl_reg - PL_W'(take);
    assign em_done  = (pl_after == '0);

    always_comb
    begin
        if (cfg.strip_rows == '0)
            rows_c = ROWS_W'(1);
        else if (cfg.strip_rows > ROWS_W'(MAX_ROWS))
            rows_c = ROWS_W'(MAX_ROWS);
        else
            rows_c = cfg.strip_rows;
    end

    always_comb
    begin
        store_next  = store_reg;
        cnt_next    = cnt_reg;
        color_next  = color_reg;
        pl_next     = pl_reg;
        active_next = active_reg;
        if (cmd.accept)
        begin
            if (strip_start)
            begin
                store_next  = '0;
                cnt_next    = '0;
                color_next  = data_byte;
                pl_next     = {rows_c, 3'b000};
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                store_next = store_reg | (STORE_W'(data_byte) << cnt_reg);
                cnt_next   = cnt_reg + CNT_W'(8);
            end
        end
        else if (emit)
        begin
            color_next = em_color;
            pl_next    = pl_after;
            if (cmd.emit_code)
            begin
                store_next = store_reg >> consume;
                cnt_next   = cnt_reg - CNT_W'(consume);
            end
            if (em_done)
            begin
                active_next = 1'b0;
                store_next  = '0;
                cnt_next    = '0;
            end
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        oc_next = oc_reg;
        ol_next = ol_reg;
        ot_next = ot_reg;
        od_next = od_reg;
        if (emit)
        begin
            ov_next = 1'b1;
            oc_next = em_color;
            ol_next = take;
            ot_next = cfg.transparent_on && (em_color == cfg.transparent_color);
            od_next = em_done;
        end
        else if (!out_stall)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg  <= '0;
            cnt_reg    <= '0;
            color_reg  <= '0;
            pl_reg     <= '0;
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            store_reg  <= store_next;
            cnt_reg    <= cnt_next;
            color_reg  <= color_next;
            pl_reg     <= pl_next;
            active_reg <= active_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oc_reg <= oc_next;
        ol_reg <= ol_next;
        ot_reg <= ot_next;
        od_reg <= od_next;
    end

    assign out_valid      = ov_reg;
    assign color_index    = oc_reg;
    assign run_length     = ol_reg;
    assign is_transparent = ot_reg;
    assign strip_done     = od_reg;

    assign sts.active    = active_reg;
    assign sts.code_ok   = code_ok;
    assign sts.emit_done = em_done;
    assign sts.slot_free = !ov_reg || !out_stall;
    assign sts.bit_cnt   = cnt_reg;

endmodule

/* rtl/strip_complex_pixel_decoder_top.sv */
// strip pixel decoder, complex-code variant
// input channel (in_valid / in_stall): one compressed byte per transaction;
//   strip_start marks the start color byte of a new strip
// output channel (out_valid / out_stall): one transaction per decoded code,
//   giving color_index, run_length (1..256), is_transparent and strip_done
// apb port: color_bits @0x0, transparent_on @0x4, transparent_color @0x8,
//   strip_rows @0xc; pready is tied high, write only while the decoder is idle
// timing: an accepted byte occupies the decoder until the codes that it completes
//   (at most 10 per byte) are decoded; one code is decoded per cycle while the
//   output has room, by the shared decode unit working on the 24-bit bit store
// the first result of a byte is decoded in the decode state, after acceptance in idle, and then registered
// a start byte passes through the start state and gives its single pixel
// when the receiver stalls, the decoder holds in its output register and
//   waits; in_stall stays high until the byte is fully decoded
// reset: config returns to defaults, the decoder goes idle and drops any
//   pending result; bytes without strip_start are ignored until a strip starts
module strip_complex_pixel_decoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scpd_pkg::ADDR_W-1:0]   paddr,
    input  logic [scpd_pkg::DATA_W-1:0]   pwdata,
    output logic [scpd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          strip_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    color_index,
    output logic [scpd_pkg::LEN_W-1:0]    run_length,
    output logic                          is_transparent,
    output logic                          strip_done
);
    import scpd_pkg::*;

    scpd_cfg_t cfg;
    scpd_cmd_t cmd;
    scpd_sts_t sts;

    // configuration registers
    scpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: accept, then a start pixel or one code per cycle while the output has room
    scpd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .strip_start (strip_start),
        .in_stall    (in_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    // bit store, decode unit, pixel counter and output register
    scpd_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .data_byte      (data_byte),
        .strip_start    (strip_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .color_index    (color_index),
        .run_length     (run_length),
        .is_transparent (is_transparent),
        .strip_done     (strip_done)
    );

`ifndef SYNTHESIS
    // a result is only produced when the output register can take it
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_start || cmd.emit_code) |-> sts.slot_free)
        else $error("emit while output register blocked");

    // decode commands are exclusive of each other and of acceptance
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cmd) <= 1)
        else $error("overlapping sequencer commands");

    // codes are only decoded inside an active strip
    a_code_active: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_code |-> (sts.active && sts.code_ok))
        else $error("code decoded outside a strip");

    // the bit store never holds more than a partial code plus one byte
    a_bit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        sts.bit_cnt <= 5'd20)
        else $error("bit store overfilled");
`endif

endmodule
